/* design/spq_pkg.sv */
package spq_pkg;

	// Width of the reported entry count; larger fills wrap modulo 32.
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned PRIO_W  = 16;
	localparam int unsigned TAG_W   = 32;

	// Operation codes carried by each request item.
	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_PEEK  = 2'd2,
		OP_CLEAR = 2'd3
	} opcode_t;

	// One stored entry.
	typedef struct packed {
		logic signed [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]         tag;
	} entry_t;

	// Per-cycle command broadcast to every cell.
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

	// Request item.
	typedef struct packed {
		opcode_t                  opcode;
		logic signed [PRIO_W-1:0] priority_req;
		logic [TAG_W-1:0]         data_tag;
	} req_item_t;

	// Response item.
	typedef struct packed {
		logic signed [PRIO_W-1:0] head_priority;
		logic [TAG_W-1:0]         head_tag;
		logic [COUNT_W-1:0]       entry_count;
		logic                     is_empty;
		logic                     fault;
	} rsp_item_t;

endpackage

/* design/spq_cell.sv */
module spq_cell (
	input  logic                clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic                occupied,
	input  spq_pkg::entry_t     new_entry,
	input  spq_pkg::entry_t     left_entry,
	input  logic                left_stay,
	input  spq_pkg::entry_t     right_entry,
	output spq_pkg::entry_t     entry,
	output logic                stay
);

	spq_pkg::entry_t entry_q;

	// The entry stays in place on a push when it ranks at or above the new one.
	// The list is sorted, so the staying cells form a prefix of the row.
	assign stay  = occupied && (entry_q.prio >= new_entry.prio);
	assign entry = entry_q;

	// A push keeps, inserts or shifts right; a pop shifts left.
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			if (!stay) begin
				if (left_stay) begin
					entry_q <= new_entry;
				end else begin
					entry_q <= left_entry;
				end
			end
		end else if (ctrl.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

/* design/sorted_priority_queue_core.sv */
// Sorted priority queue of up to CAPACITY (priority, tag) entries, highest
// priority at the head; equal priorities leave in push order.
// Request channel req_valid/req_ready/req carries an opcode (push, pop, peek,
// clear) with a priority and tag used by push. Every request item yields
// exactly one response item on rsp_valid/rsp_ready/rsp with the head entry
// (pop and peek), the entry count after the operation, an empty flag and a
// fault flag (pop or peek on empty, push on full; the store is then unchanged).
// The entries sit in a row of cells. On a push every cell compares its entry
// with the new one in parallel and either keeps it, takes the new entry or
// takes its left neighbor's; on a pop every cell takes its right neighbor's.
// An item thus completes at once: the response is registered and shows in the
// cycle after acceptance; one item per cycle holds unless the receiver stalls.
// The response register is the only buffer: while it holds an untaken
// response, req_ready follows rsp_ready, so a stalled receiver stalls input.
// Reset (arst_n low) empties the queue and drops any pending response; the
// entry storage itself is not cleared and needs no clearing pass.
module sorted_priority_queue_core #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  spq_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output spq_pkg::rsp_item_t rsp
);

	localparam int unsigned OCC_W = $clog2(CAPACITY + 1);

	logic [OCC_W-1:0]    occ_q;
	logic [OCC_W-1:0]    occ_next;
	logic                rsp_valid_q;
	spq_pkg::rsp_item_t  rsp_q;
	spq_pkg::rsp_item_t  rsp_next;
	spq_pkg::cell_ctrl_t ctrl;
	spq_pkg::entry_t     new_entry;
	spq_pkg::entry_t     cell_entry [CAPACITY];
	logic                cell_stay  [CAPACITY];
	logic                accept;
	logic                is_full;
	logic                is_none;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign is_full   = (occ_q == OCC_W'(CAPACITY));
	assign is_none   = (occ_q == '0);

	assign new_entry.prio = req.priority_req;
	assign new_entry.tag  = req.data_tag;

	// Decode the operation and build the response.
	always_comb begin
		ctrl     = '0;
		occ_next = occ_q;
		rsp_next = '0;
		if (accept) begin
			unique case (req.opcode)
				spq_pkg::OP_PUSH: begin
					if (is_full) begin
						rsp_next.fault = 1'b1;
					end else begin
						ctrl.push = 1'b1;
						occ_next  = occ_q + OCC_W'(1);
					end
				end
				spq_pkg::OP_POP, spq_pkg::OP_PEEK: begin
					if (is_none) begin
						rsp_next.fault = 1'b1;
					end else begin
						rsp_next.head_priority = cell_entry[0].prio;
						rsp_next.head_tag      = cell_entry[0].tag;
						if (req.opcode == spq_pkg::OP_POP) begin
							ctrl.pop = 1'b1;
							occ_next = occ_q - OCC_W'(1);
						end
					end
				end
				spq_pkg::OP_CLEAR: begin
					occ_next = '0;
				end
				default: begin
					occ_next = occ_q;
				end
			endcase
		end
		rsp_next.entry_count = spq_pkg::COUNT_W'(occ_next);
		rsp_next.is_empty    = (occ_next == '0);
	end

	// Row of storage cells, each wired to its two neighbors.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_pkg::entry_t left_entry;
		spq_pkg::entry_t right_entry;
		logic            left_stay;

		if (i == 0) begin : g_first
			assign left_entry = new_entry;
			assign left_stay  = 1'b1;
		end else begin : g_mid
			assign left_entry = cell_entry[i-1];
			assign left_stay  = cell_stay[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = cell_entry[i];
		end else begin : g_inner
			assign right_entry = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (OCC_W'(i) < occ_q),
			.new_entry   (new_entry),
			.left_entry  (left_entry),
			.left_stay   (left_stay),
			.right_entry (right_entry),
			.entry       (cell_entry[i]),
			.stay        (cell_stay[i])
		);
	end

	// Fill count and response handshake state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			occ_q <= occ_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* design/spq_checker.sv */
module spq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input spq_pkg::req_item_t req,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input spq_pkg::rsp_item_t rsp
);

	// A faulting response never reports a head entry.
	a_fault_no_head: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.fault |-> rsp.head_priority == '0 && rsp.head_tag == '0)
		else $error("faulting response carries head data");

	// An empty queue reports a zero count.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_empty |-> rsp.entry_count == '0)
		else $error("empty queue with nonzero count");

	// A clear answers in the next cycle, empty and without fault.
	a_clear_resp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.opcode == spq_pkg::OP_CLEAR
		|=> rsp_valid && rsp.is_empty && !rsp.fault)
		else $error("clear did not answer empty");

	// A stalled response holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);

/* tb/sv/testbench.sv */
module testbench;

	localparam int QUEUE_DEPTH  = 16;
	localparam int RANDOM_ITEMS = 430;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 80;
	localparam int HOLD_EVERY   = 150;
	localparam int HOLD_COUNT   = 2;
	localparam int DRAIN_CYCLES = 8;

	// Receiver stall styles, switched at random intervals.
	typedef enum int {
		RX_OPEN,
		RX_RANDOM,
		RX_PERIODIC,
		RX_SPARSE
	} rx_mode_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	spq_pkg::req_item_t req       = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	spq_pkg::rsp_item_t rsp;

	// Requests waiting to be offered and responses waiting to be checked.
	spq_pkg::req_item_t pending_reqs[$];
	spq_pkg::rsp_item_t expected_rsps[$];

	// Shadow copy of the sorted store, head at index zero.
	logic signed [spq_pkg::PRIO_W-1:0] shadow_prio [QUEUE_DEPTH];
	logic [spq_pkg::TAG_W-1:0]         shadow_tag  [QUEUE_DEPTH];
	int                                shadow_count = 0;

	int error_count       = 0;
	int responses_checked = 0;
	int fault_count       = 0;
	int full_pushes       = 0;
	int op_counts [4]     = '{default: 0};

	int       gap_left    = 0;
	int       burst_left  = 0;
	int       idle_cycles = 0;
	int       rx_taken    = 0;
	int       hold_left   = 0;
	int       holds_done  = 0;
	int       mode_left   = 0;
	int       rx_phase    = 0;
	rx_mode_t rx_mode     = RX_OPEN;

	sorted_priority_queue_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// Applies one request to the shadow store and returns the response it should produce.
	function automatic spq_pkg::rsp_item_t queue_step(spq_pkg::req_item_t r);
		spq_pkg::rsp_item_t res;
		int                 pos;
		res = '0;
		case (r.opcode)
			spq_pkg::OP_PUSH: begin
				if (shadow_count >= QUEUE_DEPTH) begin
					res.fault = 1'b1;
					full_pushes++;
				end else begin
					// A new entry goes behind every entry of equal or higher priority.
					pos = 0;
					while (pos < shadow_count &&
						$signed(shadow_prio[pos]) >= $signed(r.priority_req))
						pos++;
					for (int i = shadow_count; i > pos; i--) begin
						shadow_prio[i] = shadow_prio[i-1];
						shadow_tag[i]  = shadow_tag[i-1];
					end
					shadow_prio[pos] = r.priority_req;
					shadow_tag[pos]  = r.data_tag;
					shadow_count++;
				end
			end
			spq_pkg::OP_POP, spq_pkg::OP_PEEK: begin
				if (shadow_count == 0) begin
					res.fault = 1'b1;
				end else begin
					res.head_priority = shadow_prio[0];
					res.head_tag      = shadow_tag[0];
					if (r.opcode == spq_pkg::OP_POP) begin
						for (int i = 1; i < shadow_count; i++) begin
							shadow_prio[i-1] = shadow_prio[i];
							shadow_tag[i-1]  = shadow_tag[i];
						end
						shadow_count--;
					end
				end
			end
			default: begin
				shadow_count = 0;
			end
		endcase
		if (res.fault)
			fault_count++;
		res.entry_count = spq_pkg::COUNT_W'(shadow_count);
		res.is_empty    = (shadow_count == 0);
		return res;
	endfunction

	// Priorities drawn from a tight band to force ties, from the extremes, or from anywhere.
	function automatic logic signed [spq_pkg::PRIO_W-1:0] pick_priority();
		case ($urandom_range(0, 3))
			0: return spq_pkg::PRIO_W'($urandom_range(0, 4) - 2);
			1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			default: return spq_pkg::PRIO_W'($urandom());
		endcase
	endfunction

	task automatic add_request(spq_pkg::opcode_t op, logic signed [spq_pkg::PRIO_W-1:0] prio,
		logic [spq_pkg::TAG_W-1:0] tag);
		spq_pkg::req_item_t item;
		item.opcode       = op;
		item.priority_req = prio;
		item.data_tag     = tag;
		pending_reqs.push_back(item);
	endtask

	// The driver offers pending items in bursts separated by random gaps.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_ready) begin
			if (gap_left > 0) begin
				gap_left  <= gap_left - 1;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				req       <= pending_reqs.pop_front();
				req_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// The receiver changes its stall style now and then and holds off twice for a long stretch.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			rx_phase <= rx_phase + 1;
			if (rsp_valid && rsp_ready)
				rx_taken <= rx_taken + 1;
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp_ready <= 1'b0;
			end else if (holds_done < HOLD_COUNT &&
				rx_taken >= (holds_done + 1) * HOLD_EVERY) begin
				hold_left  <= HOLD_CYCLES;
				holds_done <= holds_done + 1;
				rsp_ready  <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode   <= rx_mode_t'($urandom_range(0, 3));
					mode_left <= $urandom_range(16, 64);
				end else begin
					mode_left <= mode_left - 1;
				end
				case (rx_mode)
					RX_OPEN:     rsp_ready <= 1'b1;
					RX_RANDOM:   rsp_ready <= 1'($urandom_range(0, 1));
					RX_PERIODIC: rsp_ready <= (rx_phase % 3 != 0);
					default:     rsp_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// The monitor checks each taken response, then records the expectation for each accepted item.
	always @(posedge clk) begin
		spq_pkg::rsp_item_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("ERROR: unexpected item: prio %0d tag %h count %0d",
							rsp.head_priority, rsp.head_tag, rsp.entry_count);
				end else begin
					want = expected_rsps.pop_front();
					responses_checked++;
					if (rsp.head_priority !== want.head_priority ||
						rsp.head_tag !== want.head_tag ||
						rsp.entry_count !== want.entry_count ||
						rsp.is_empty !== want.is_empty ||
						rsp.fault !== want.fault) begin
						error_count++;
						if (error_count <= 10) begin
							$display("ERROR: item %0d expected prio %0d tag %h count %0d empty %b fault %b",
								responses_checked, want.head_priority, want.head_tag,
								want.entry_count, want.is_empty, want.fault);
							$display("ERROR: item %0d actual   prio %0d tag %h count %0d empty %b fault %b",
								responses_checked, rsp.head_priority, rsp.head_tag,
								rsp.entry_count, rsp.is_empty, rsp.fault);
						end
					end
				end
			end
			if (req_valid && req_ready) begin
				expected_rsps.push_back(queue_step(req));
				op_counts[req.opcode]++;
			end
		end
	end

	// The watchdog ends a run in which nothing moves for too long.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
				$display("sorted_priority_queue_core verification failed");
				$finish;
			end
		end
	end

	// Build the stimulus, release reset and wait for the queue to drain.
	initial begin
		int               kind;
		int               len;
		int               pick;
		int               random_start;
		spq_pkg::opcode_t op;

		// Faulting reads and a clear on an empty queue.
		add_request(spq_pkg::OP_CLEAR, 16'sh0000, 32'h0000_0000);
		add_request(spq_pkg::OP_POP,   16'sh7FFF, 32'hFFFF_FFFF);
		add_request(spq_pkg::OP_PEEK,  16'sh8000, 32'h0000_0000);
		// Priority extremes, a tie at zero and a negative entry.
		add_request(spq_pkg::OP_PUSH, 16'sh7FFF, 32'hFFFF_FFFF);
		add_request(spq_pkg::OP_PUSH, 16'sh8000, 32'h0000_0000);
		add_request(spq_pkg::OP_PUSH, 16'sh0000, 32'h0000_0001);
		add_request(spq_pkg::OP_PUSH, 16'sh0000, 32'h8000_0000);
		add_request(spq_pkg::OP_PUSH, 16'shFFFF, 32'hA5A5_A5A5);
		add_request(spq_pkg::OP_PEEK, 16'sh0000, 32'h0000_0000);
		// Drain everything and pop once more on the empty queue.
		repeat (6)
			add_request(spq_pkg::OP_POP, 16'sh0000, 32'h0000_0000);
		// Clear a non-empty queue, then peek it.
		add_request(spq_pkg::OP_PUSH,  16'sh0001, 32'h5A5A_5A5A);
		add_request(spq_pkg::OP_CLEAR, 16'sh7FFF, 32'hFFFF_FFFF);
		add_request(spq_pkg::OP_PEEK,  16'sh0000, 32'h0000_0000);

		// Random sequences: fills past capacity, drains past empty, and mixed traffic.
		random_start = pending_reqs.size();
		while (pending_reqs.size() - random_start < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind < 3) begin
				len = $urandom_range(QUEUE_DEPTH - 4, QUEUE_DEPTH + 4);
				repeat (len)
					add_request(spq_pkg::OP_PUSH, pick_priority(), $urandom());
			end else if (kind < 5) begin
				len = $urandom_range(4, QUEUE_DEPTH + 4);
				repeat (len) begin
					if ($urandom_range(0, 4) == 0)
						op = spq_pkg::OP_PEEK;
					else
						op = spq_pkg::OP_POP;
					add_request(op, spq_pkg::PRIO_W'($urandom()), $urandom());
				end
			end else if (kind < 9) begin
				len = $urandom_range(8, 30);
				repeat (len) begin
					pick = $urandom_range(0, 99);
					if (pick < 45)
						add_request(spq_pkg::OP_PUSH, pick_priority(), $urandom());
					else if (pick < 75)
						add_request(spq_pkg::OP_POP, spq_pkg::PRIO_W'($urandom()), $urandom());
					else if (pick < 93)
						add_request(spq_pkg::OP_PEEK, spq_pkg::PRIO_W'($urandom()), $urandom());
					else
						add_request(spq_pkg::OP_CLEAR, spq_pkg::PRIO_W'($urandom()), $urandom());
				end
			end else begin
				add_request(spq_pkg::OP_CLEAR, spq_pkg::PRIO_W'($urandom()), $urandom());
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items (%0d push, %0d pop, %0d peek, %0d clear), %0d faulting.",
			op_counts[spq_pkg::OP_PUSH] + op_counts[spq_pkg::OP_POP] +
			op_counts[spq_pkg::OP_PEEK] + op_counts[spq_pkg::OP_CLEAR],
			op_counts[spq_pkg::OP_PUSH], op_counts[spq_pkg::OP_POP],
			op_counts[spq_pkg::OP_PEEK], op_counts[spq_pkg::OP_CLEAR], fault_count);
		$display("Checked %0d responses; %0d pushes hit a full queue; %0d long hold-offs.",
			responses_checked, full_pushes, holds_done);
		if (error_count == 0)
			$display("sorted_priority_queue_core verification clean");
		else
			$display("sorted_priority_queue_core verification failed");
		$finish;
	end

endmodule
